// File: sv/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg
// Shared types and constants for the keyword substitution cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package kwsc_pkg;

    localparam int unsigned LETTERS = 26;

    // transaction op codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;

    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);

    typedef logic [4:0] letter_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_key;
        logic add_key;
        logic do_text;
        logic build_start;
        logic key_step;
        logic fill_step;
        logic build_done;
    } kwsc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stale;
        logic out_free;
        logic keys_done;
        logic scan_last;
    } kwsc_stat_t;

endpackage

`default_nettype wire

// File: sv/keyword_substitution_cipher_core.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_core
// Keyword substitution cipher on a byte stream: keyword load and text mapping.
// ----------------------------------------------------------------------------
//  Channel   Signals                         Direction  Handshake
//  input     op, data_byte                   in         in_valid / in_stall
//  output    out_byte                        out        out_valid / out_stall
//  config    cfg_wr_data (decrypt_mode)      in         cfg_wr_en
//
//  Keyword and text transactions are taken at one per cycle outside a
//  rebuild. The first text byte after a keyword change waits while the
//  tables are rebuilt: key letters first, then unused letters from Z down.
//  Text results sit in an output register; outside a rebuild, in_stall rises
//  for a text byte only while that register is full and out_stall is high.
//  Reset leaves an empty keyword and marks the tables for rebuild.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_substitution_cipher_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte
);
    import kwsc_pkg::*;

    kwsc_cmd_t  cmd;
    kwsc_stat_t stat;

    kwsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .stat     (stat),
        .cmd      (cmd)
    );

    kwsc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte)
    );

endmodule

`default_nettype wire

// File: sv/kwsc_ctrl.sv
// ----------------------------------------------------------------------------
// kwsc_ctrl
// Input handshake and table build sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module kwsc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            op,
    input  wire kwsc_pkg::kwsc_stat_t  stat,
    output kwsc_pkg::kwsc_cmd_t        cmd
);
    import kwsc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEYS = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                case (op)
                    OP_CLEAR:
                    begin
                        in_stall      = 1'b0;
                        cmd.clear_key = in_valid;
                    end
                    OP_KEY:
                    begin
                        in_stall    = 1'b0;
                        cmd.add_key = in_valid;
                    end
                    OP_TEXT:
                    begin
                        if (stat.stale)
                        begin
                            // hold the text byte until the tables are rebuilt
                            if (in_valid)
                            begin
                                cmd.build_start = 1'b1;
                                state_next      = ST_KEYS;
                            end
                        end
                        else
                        begin
                            in_stall    = !stat.out_free;
                            cmd.do_text = in_valid && stat.out_free;
                        end
                    end
                    default:
                    begin
                        in_stall = 1'b0;
                    end
                endcase
            end
            ST_KEYS:
            begin
                if (stat.keys_done)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cmd.key_step = 1'b1;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.build_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/kwsc_datapath.sv
// ----------------------------------------------------------------------------
// kwsc_datapath
// Key list, cipher tables, build counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kwsc_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic [7:0]            data_byte,
    input  wire kwsc_pkg::kwsc_cmd_t   cmd,
    output kwsc_pkg::kwsc_stat_t       stat,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 out_byte
);
    import kwsc_pkg::*;

    letter_t            key_letters_mem [LETTERS];
    letter_t            enc_mem         [LETTERS];
    letter_t            dec_mem         [LETTERS];

    logic               decrypt_mode_reg;
    logic [LETTERS-1:0] letter_seen_reg;
    logic [LETTERS-1:0] letter_seen_next;
    logic [4:0]         key_count_reg;
    logic [4:0]         key_count_next;
    logic               stale_reg;
    logic               stale_next;
    logic [4:0]         pos_reg;
    logic [4:0]         pos_next;
    letter_t            scan_reg;
    letter_t            scan_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    letter_t            key_rd_reg;

    logic [7:0]         up_byte;
    logic               is_letter;
    letter_t            letter_idx;
    logic               key_new;
    logic               enc_we;
    letter_t            enc_wdata;

    always_comb
    begin
        if (data_byte inside {[CHAR_LC_A:CHAR_LC_Z]})
        begin
            up_byte = data_byte - CASE_OFFSET;
        end
        else
        begin
            up_byte = data_byte;
        end
    end

    assign is_letter  = up_byte inside {[CHAR_UC_A:CHAR_UC_Z]};
    assign letter_idx = is_letter ? 5'(up_byte - CHAR_UC_A) : '0;
    assign key_new    = is_letter && !letter_seen_reg[letter_idx];

    // build: key letters first, then unused letters scanned from Z down
    assign enc_we    = cmd.key_step || (cmd.fill_step && !letter_seen_reg[scan_reg]);
    assign enc_wdata = cmd.key_step ? key_rd_reg : scan_reg;

    always_comb
    begin
        letter_seen_next = letter_seen_reg;
        key_count_next   = key_count_reg;
        stale_next       = stale_reg;
        pos_next         = pos_reg;
        scan_next        = scan_reg;
        out_valid_next   = out_valid_reg;

        if (cmd.clear_key)
        begin
            letter_seen_next = '0;
            key_count_next   = '0;
            stale_next       = 1'b1;
        end
        if (cmd.add_key && key_new)
        begin
            letter_seen_next[letter_idx] = 1'b1;
            key_count_next               = key_count_reg + 5'd1;
            stale_next                   = 1'b1;
        end
        if (cmd.build_start)
        begin
            pos_next  = '0;
            scan_next = LAST_LETTER;
        end
        if (enc_we)
        begin
            pos_next = pos_reg + 5'd1;
        end
        if (cmd.fill_step && !cmd.build_done)
        begin
            scan_next = scan_reg - 5'd1;
        end
        if (cmd.build_done)
        begin
            stale_next = 1'b0;
        end

        if (cmd.do_text)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
            letter_seen_reg  <= '0;
            key_count_reg    <= '0;
            stale_reg        <= 1'b1;
            pos_reg          <= '0;
            scan_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                decrypt_mode_reg <= cfg_wr_data;
            end
            letter_seen_reg <= letter_seen_next;
            key_count_reg   <= key_count_next;
            stale_reg       <= stale_next;
            pos_reg         <= pos_next;
            scan_reg        <= scan_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_text)
        begin
            if (!is_letter)
            begin
                out_byte_reg <= up_byte;
            end
            else if (decrypt_mode_reg)
            begin
                out_byte_reg <= CHAR_UC_A + {3'b000, dec_mem[letter_idx]};
            end
            else
            begin
                out_byte_reg <= CHAR_UC_A + {3'b000, enc_mem[letter_idx]};
            end
        end
        // key list read registered from pos_next, ready for the key step that uses it
        key_rd_reg <= key_letters_mem[pos_next];
        if (cmd.add_key && key_new)
        begin
            key_letters_mem[key_count_reg] <= letter_idx;
        end
        // inverse table written alongside, so no second pass is needed
        if (enc_we)
        begin
            enc_mem[pos_reg]   <= enc_wdata;
            dec_mem[enc_wdata] <= pos_reg;
        end
    end

    always_comb
    begin
        stat.stale     = stale_reg;
        stat.out_free  = !out_valid_reg || !out_stall;
        stat.keys_done = (pos_reg == key_count_reg);
        stat.scan_last = (scan_reg == '0);
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

`default_nettype wire
